[rtl/core/crlc_pkg.sv]
`default_nettype none
package crlc_pkg;

  localparam int LEVEL_BITS  = 16;
  localparam int COST_BITS   = 16;
  localparam int CFG_W       = 10;
  localparam int TABLE_W     = 64;
  localparam int CFG_DATA_W  = 64;
  localparam int STORE_DEPTH = 68;
  localparam int STORE_AW    = 7;

  // DC coefficients live above the four AC blocks in the shared store.
  localparam logic [STORE_AW-1:0] DC_BASE = STORE_AW'(64);

  localparam logic [CFG_W-1:0]   COST_THRESHOLD_RST   = CFG_W'(4);
  localparam logic [CFG_W-1:0]   LARGE_LEVEL_COST_RST = CFG_W'(999);
  localparam logic [TABLE_W-1:0] RUN_COST_TABLE_RST   = TABLE_W'(1118755);

  typedef enum logic [1:0] {
    CFG_COST_THRESHOLD   = 2'd0,
    CFG_LARGE_LEVEL_COST = 2'd1,
    CFG_RUN_COST_TABLE   = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic                         kind;
    logic [1:0]                   ac_block;
    logic [3:0]                   position;
    logic signed [LEVEL_BITS-1:0] coefficient;
    logic                         end_of_macroblock;
  } in_item_t;

  typedef struct packed {
    logic                         from_ac;
    logic [1:0]                   source_block;
    logic [3:0]                   zero_run;
    logic signed [LEVEL_BITS-1:0] level_value;
    logic                         no_pair;
    logic                         last_result;
    logic [1:0]                   block_pattern;
    logic                         ac_cleared;
  } out_item_t;

  typedef struct packed {
    logic                  wr_en;
    logic [STORE_AW-1:0]   wr_addr;
    logic [LEVEL_BITS-1:0] wr_data;
    logic                  rd_en;
    logic [STORE_AW-1:0]   rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic signed [LEVEL_BITS-1:0] level;
    logic [3:0]                   run;
    logic [COST_BITS-1:0]         cost;
    logic [CFG_W-1:0]             large_cost;
    logic [TABLE_W-1:0]           run_table;
  } unit_in_t;

  typedef struct packed {
    logic                 nonzero;
    logic [3:0]           next_run;
    logic [COST_BITS-1:0] cost_sum;
  } unit_out_t;

  // Zigzag scan order of a 4x4 block: scan position to raster position.
  function automatic logic [3:0] zigzag(input logic [3:0] scan_pos);
    logic [3:0] r;
    case (scan_pos)
      4'd0:    r = 4'd0;
      4'd1:    r = 4'd1;
      4'd2:    r = 4'd4;
      4'd3:    r = 4'd8;
      4'd4:    r = 4'd5;
      4'd5:    r = 4'd2;
      4'd6:    r = 4'd3;
      4'd7:    r = 4'd6;
      4'd8:    r = 4'd9;
      4'd9:    r = 4'd12;
      4'd10:   r = 4'd13;
      4'd11:   r = 4'd10;
      4'd12:   r = 4'd7;
      4'd13:   r = 4'd11;
      4'd14:   r = 4'd14;
      4'd15:   r = 4'd15;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/core/crlc_store.sv]
`default_nettype none
module crlc_store
  import crlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire mem_req_t              req,
  output logic [LEVEL_BITS-1:0]      rd_data
);

  logic [LEVEL_BITS-1:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule
`default_nettype wire

[rtl/core/crlc_unit.sv]
`default_nettype none
module crlc_unit
  import crlc_pkg::*;
(
  input  wire unit_in_t  ui,
  output unit_out_t      uo
);

  logic             nz;
  logic             big;
  logic [3:0]       nib;
  logic [CFG_W-1:0] inc;
  logic [7:0]       sh;

  always_comb begin
    nz  = (ui.level != '0);
    // Magnitude above one: nonzero and neither +1 nor -1.
    big = nz && (ui.level != LEVEL_BITS'(1)) && (ui.level != '1);
    sh  = {2'b00, ui.run, 2'b00};
    nib = 4'(ui.run_table >> sh);
    inc = big ? ui.large_cost : CFG_W'(nib);
    uo.nonzero  = nz;
    uo.next_run = nz ? 4'd0 : ui.run + 4'd1;
    uo.cost_sum = ui.cost + COST_BITS'(inc);
  end

endmodule
`default_nettype wire

[rtl/core/crlc_ctrl.sv]
`default_nettype none
module crlc_ctrl
  import crlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic [CFG_W-1:0]      cost_threshold,
  input  wire logic [CFG_W-1:0]      large_cost,
  input  wire logic [TABLE_W-1:0]    run_table,
  output mem_req_t                   mem_req,
  input  wire logic [LEVEL_BITS-1:0] rd_data,
  output unit_in_t                   unit_in,
  input  wire unit_out_t             unit_out
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_READ   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    PH_COST = 2'd0,
    PH_DC   = 2'd1,
    PH_AC   = 2'd2
  } phase_t;

  state_t               state_r, state_nxt;
  phase_t               phase_r, phase_nxt;
  logic [1:0]           blk_r, blk_nxt;
  logic [3:0]           idx_r, idx_nxt;
  logic [3:0]           run_r, run_nxt;
  logic [COST_BITS-1:0] cost_r, cost_nxt;
  logic                 ac_nz_r, ac_nz_nxt;
  logic                 dc_coded_r, dc_coded_nxt;
  logic                 cleared_r, cleared_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  out_item_t            pend_r, pend_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_r, out_nxt;

  logic                 accept_in;
  logic                 slot_free;
  logic                 need_push;
  logic                 stall;
  logic [COST_BITS-1:0] new_cost;
  logic [1:0]           pattern;

  assign in_ready  = (state_r == S_IDLE);
  assign accept_in = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    mem_req.wr_en   = accept_in;
    mem_req.wr_addr = in_data.kind ? {1'b0, in_data.ac_block, in_data.position}
                                   : DC_BASE + STORE_AW'(in_data.position[1:0]);
    mem_req.wr_data = in_data.coefficient;
    mem_req.rd_en   = (state_r == S_READ);
    mem_req.rd_addr = (phase_r == PH_DC) ? DC_BASE + STORE_AW'(idx_r[1:0])
                                         : {1'b0, blk_r, zigzag(idx_r)};
  end

  always_comb begin
    unit_in.level      = rd_data;
    unit_in.run        = run_r;
    unit_in.cost       = cost_r;
    unit_in.large_cost = large_cost;
    unit_in.run_table  = run_table;
  end

  assign need_push = (state_r == S_EVAL) && (phase_r != PH_COST) &&
                     unit_out.nonzero && pend_valid_r;
  assign stall     = need_push && !slot_free;
  assign new_cost  = unit_out.nonzero ? unit_out.cost_sum : cost_r;
  assign pattern   = (ac_nz_r && !cleared_r) ? 2'd2 : (dc_coded_r ? 2'd1 : 2'd0);

  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    blk_nxt        = blk_r;
    idx_nxt        = idx_r;
    run_nxt        = run_r;
    cost_nxt       = cost_r;
    ac_nz_nxt      = ac_nz_r;
    dc_coded_nxt   = dc_coded_r;
    cleared_nxt    = cleared_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_nxt        = out_r;

    case (state_r)
      S_IDLE: begin
        if (accept_in && in_data.end_of_macroblock) begin
          state_nxt      = S_READ;
          phase_nxt      = PH_COST;
          blk_nxt        = 2'd0;
          idx_nxt        = 4'd1;
          run_nxt        = 4'd0;
          cost_nxt       = '0;
          ac_nz_nxt      = 1'b0;
          dc_coded_nxt   = 1'b0;
          pend_valid_nxt = 1'b0;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!stall) begin
          state_nxt = S_READ;
          run_nxt   = unit_out.next_run;
          if (need_push) begin
            out_valid_nxt = 1'b1;
            out_nxt       = pend_r;
          end
          case (phase_r)
            PH_COST: begin
              cost_nxt = new_cost;
              if (unit_out.nonzero) begin
                ac_nz_nxt = 1'b1;
              end
              if (idx_r == 4'd15) begin
                run_nxt = 4'd0;
                idx_nxt = 4'd1;
                blk_nxt = blk_r + 2'd1;
                if (blk_r == 2'd3) begin
                  phase_nxt   = PH_DC;
                  idx_nxt     = 4'd0;
                  cleared_nxt = (new_cost < COST_BITS'(cost_threshold));
                end
              end else begin
                idx_nxt = idx_r + 4'd1;
              end
            end
            PH_DC: begin
              if (unit_out.nonzero) begin
                pend_valid_nxt           = 1'b1;
                pend_nxt                 = '0;
                pend_nxt.zero_run        = run_r;
                pend_nxt.level_value     = rd_data;
                dc_coded_nxt             = 1'b1;
              end
              if (idx_r == 4'd3) begin
                run_nxt = 4'd0;
                blk_nxt = 2'd0;
                idx_nxt = 4'd1;
                if (cleared_r) begin
                  state_nxt = S_FINISH;
                end else begin
                  phase_nxt = PH_AC;
                end
              end else begin
                idx_nxt = idx_r + 4'd1;
              end
            end
            PH_AC: begin
              if (unit_out.nonzero) begin
                pend_valid_nxt        = 1'b1;
                pend_nxt              = '0;
                pend_nxt.from_ac      = 1'b1;
                pend_nxt.source_block = blk_r;
                pend_nxt.zero_run     = run_r;
                pend_nxt.level_value  = rd_data;
              end
              if (idx_r == 4'd15) begin
                run_nxt = 4'd0;
                idx_nxt = 4'd1;
                if (blk_r == 2'd3) begin
                  state_nxt = S_FINISH;
                end else begin
                  blk_nxt = blk_r + 2'd1;
                end
              end else begin
                idx_nxt = idx_r + 4'd1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_FINISH: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (pend_valid_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt.no_pair = 1'b1;
          end
          out_nxt.last_result   = 1'b1;
          out_nxt.block_pattern = pattern;
          out_nxt.ac_cleared    = cleared_r;
          pend_valid_nxt        = 1'b0;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r    <= phase_nxt;
    blk_r      <= blk_nxt;
    idx_r      <= idx_nxt;
    run_r      <= run_nxt;
    cost_r     <= cost_nxt;
    ac_nz_r    <= ac_nz_nxt;
    dc_coded_r <= dc_coded_nxt;
    cleared_r  <= cleared_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

[rtl/core/chroma_run_level_coeff_cost_top.sv]
// Chroma run-level coder with an AC cost check.
// Input channel (in_valid/in_ready/in_data): one quantized coefficient per
// transaction, four DC values and four 4x4 AC blocks, the final one marked
// with end_of_macroblock. Items before the last are written into the
// coefficient store at one per cycle and give no result.
// On the last item the block scans the store with one shared evaluation unit
// under a small sequencer, each coefficient taking a registered store read
// and then an evaluation step: a cost pass over the 60 AC positions, then the
// DC block, then, unless the AC cost fell below the threshold, the AC blocks
// again in zigzag order. Results leave on out_valid/out_ready, DC pairs first,
// then AC pairs of blocks 0 to 3; the final transaction carries last_result,
// the coded block pattern and the cleared flag, or is an empty result when
// nothing was coded. in_ready is low during the scan and returns high as the
// last result enters the output.
// A stalled receiver holds the scan, since one pair waits in a lookahead
// register and one in the output register. Configuration writes
// (cfg_valid/cfg_ready) are always taken and are meant for idle periods.
// Synchronous reset restores the register defaults and empties the output.
`default_nettype none
module chroma_run_level_coeff_cost_top
  import crlc_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire in_item_t              in_data,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  logic [CFG_W-1:0]      cost_threshold_r;
  logic [CFG_W-1:0]      large_cost_r;
  logic [TABLE_W-1:0]    run_table_r;
  mem_req_t              mem_req;
  logic [LEVEL_BITS-1:0] rd_data;
  unit_in_t              unit_in;
  unit_out_t             unit_out;

  // The register file never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_threshold_r <= COST_THRESHOLD_RST;
      large_cost_r     <= LARGE_LEVEL_COST_RST;
      run_table_r      <= RUN_COST_TABLE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_COST_THRESHOLD:   cost_threshold_r <= cfg_data[CFG_W-1:0];
        CFG_LARGE_LEVEL_COST: large_cost_r     <= cfg_data[CFG_W-1:0];
        CFG_RUN_COST_TABLE:   run_table_r      <= cfg_data[TABLE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  crlc_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  crlc_unit u_unit (
    .ui (unit_in),
    .uo (unit_out)
  );

  crlc_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .cost_threshold (cost_threshold_r),
    .large_cost     (large_cost_r),
    .run_table      (run_table_r),
    .mem_req        (mem_req),
    .rd_data        (rd_data),
    .unit_in        (unit_in),
    .unit_out       (unit_out)
  );

endmodule
`default_nettype wire

[tb/sv/tb_chroma_run_level_coeff_cost_top.sv]
`timescale 1ns / 1ps

// Self-checking testbench for the chroma run-level coder.
//
// The stimulus program (an initial block) fills coeff_q with coefficient
// transactions, one phase at a time. A clocked driver offers them on the
// input channel. A clocked receiver drives out_ready, and a clocked monitor
// compares every result transaction against the oldest entry of
// pending_pairs. absorb_coeff keeps its own copy of the coefficient stores
// and of the three registers. It fills pending_pairs at the moment an input
// transaction is accepted.
module tb_chroma_run_level_coeff_cost_top;
  import crlc_pkg::*;

  localparam int HALF_PERIOD = 6;
  localparam int DRAIN_CYCLES = 300;   // longer than one full scan of the store
  localparam int LONG_HOLD = 700;      // receiver hold-off in the last phase
  localparam int QUIET_LIMIT = 3000;   // cycles without any transaction

  logic clk;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  chroma_run_level_coeff_cost_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  // Zigzag scan: scan position to raster position inside a 4x4 block.
  localparam logic [3:0] ZIGZAG [16] = '{
    4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
    4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15
  };

  // Predictor state: shadow registers and shadow coefficient stores.
  logic [CFG_W-1:0] thr_shadow = COST_THRESHOLD_RST;
  logic [CFG_W-1:0] big_cost_shadow = LARGE_LEVEL_COST_RST;
  logic [TABLE_W-1:0] run_table_shadow = RUN_COST_TABLE_RST;
  logic signed [LEVEL_BITS-1:0] dc_coef [4];
  logic signed [LEVEL_BITS-1:0] ac_coef [64];

  in_item_t coeff_q [$];        // transactions waiting to be offered
  out_item_t pending_pairs [$]; // results predicted but not yet seen

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_armed = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;
  out_item_t want_pair;

  // Stores one coefficient; on the end of a macroblock it scans both stores
  // and queues the run-level results that the block must produce.
  function automatic void absorb_coeff(input in_item_t it);
    out_item_t pairs [$];
    out_item_t r;
    logic [COST_BITS-1:0] cost;
    logic [3:0] run;
    logic signed [LEVEL_BITS-1:0] lv;
    bit dc_hit;
    bit ac_hit;
    bit cleared;
    int first_ac;
    if (it.kind == 1'b0) begin
      // Only the low two position bits pick a DC entry.
      dc_coef[it.position[1:0]] = it.coefficient;
    end else begin
      ac_coef[{it.ac_block, it.position}] = it.coefficient;
    end
    if (!it.end_of_macroblock) return;

    cost = '0;
    dc_hit = 1'b0;
    ac_hit = 1'b0;
    run = '0;
    for (int i = 0; i < 4; i++) begin
      lv = dc_coef[i];
      if (lv != 0) begin
        r = '0;
        r.zero_run = run;
        r.level_value = lv;
        pairs.insert(pairs.size(), r);
        run = '0;
        dc_hit = 1'b1;
      end else begin
        run++;
      end
    end

    first_ac = pairs.size();
    for (int b = 0; b < 4; b++) begin
      run = '0;
      // Raster position 0 of an AC block is never scanned.
      for (int s = 1; s < 16; s++) begin
        lv = ac_coef[b * 16 + ZIGZAG[s]];
        if (lv != 0) begin
          r = '0;
          r.from_ac = 1'b1;
          r.source_block = 2'(b);
          r.zero_run = run;
          r.level_value = lv;
          pairs.insert(pairs.size(), r);
          ac_hit = 1'b1;
          if (lv > 1 || lv < -1) cost = cost + COST_BITS'(big_cost_shadow);
          else cost = cost + COST_BITS'(run_table_shadow[4 * run +: 4]);
          run = '0;
        end else begin
          run++;
        end
      end
    end

    // A low total cost drops every AC pair, even when there was none.
    cleared = cost < COST_BITS'(thr_shadow);
    if (cleared) begin
      while (pairs.size() > first_ac) void'(pairs.pop_back());
      ac_hit = 1'b0;
    end

    if (pairs.size() == 0) begin
      r = '0;
      r.no_pair = 1'b1;
      pairs.insert(pairs.size(), r);
    end
    r = pairs.pop_back();
    r.last_result = 1'b1;
    r.block_pattern = ac_hit ? 2'd2 : (dc_hit ? 2'd1 : 2'd0);
    r.ac_cleared = cleared;
    pairs.insert(pairs.size(), r);
    foreach (pairs[k]) pending_pairs.insert(pending_pairs.size(), pairs[k]);
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // Input driver. A new item is only chosen once the current one has been
  // taken, so in_valid and in_data hold steady while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        absorb_coeff(in_data);
        void'(coeff_q.pop_front());
      end
      if (coeff_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= coeff_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver. In the last phase the first result triggers a long hold-off,
  // so the block backs up while the driver keeps offering coefficients.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (hold_armed && !hold_done && out_valid) begin
      hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: each accepted result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_pairs.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        errors++;
      end else begin
        want_pair = pending_pairs.pop_front();
        check_field("from_ac", want_pair.from_ac, out_data.from_ac);
        check_field("source_block", want_pair.source_block, out_data.source_block);
        check_field("zero_run", want_pair.zero_run, out_data.zero_run);
        check_field("level_value", $signed(want_pair.level_value),
                    $signed(out_data.level_value));
        check_field("no_pair", want_pair.no_pair, out_data.no_pair);
        check_field("last_result", want_pair.last_result, out_data.last_result);
        check_field("block_pattern", want_pair.block_pattern, out_data.block_pattern);
        check_field("ac_cleared", want_pair.ac_cleared, out_data.ac_cleared);
      end
    end
  end

  // Watchdog: any transaction on any channel counts as progress.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, QUIET_LIMIT);
        $display("tb_chroma_run_level_coeff_cost_top: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Register write; the shadow copy changes when the transaction completes.
  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_COST_THRESHOLD:   thr_shadow = val[CFG_W-1:0];
      CFG_LARGE_LEVEL_COST: big_cost_shadow = val[CFG_W-1:0];
      CFG_RUN_COST_TABLE:   run_table_shadow = val;
      default: ;
    endcase
  endtask

  task automatic push_coeff(input logic kind, input logic [1:0] blk, input logic [3:0] pos,
                            input logic signed [LEVEL_BITS-1:0] coef, input logic eom);
    in_item_t it;
    it.kind = kind;
    it.ac_block = blk;
    it.position = pos;
    it.coefficient = coef;
    it.end_of_macroblock = eom;
    coeff_q.insert(coeff_q.size(), it);
  endtask

  // Mostly zeros and unit levels, with a few larger and full-range values.
  function automatic logic signed [LEVEL_BITS-1:0] pick_level(input int density);
    int roll;
    logic signed [LEVEL_BITS-1:0] v;
    roll = $urandom_range(99);
    if (roll >= density) return '0;
    roll = $urandom_range(9);
    if (roll < 6) return $urandom_range(1) ? 16'sd1 : -16'sd1;
    if (roll < 9) begin
      v = 16'($urandom_range(20, 2));
      return $urandom_range(1) ? v : -v;
    end
    return 16'($urandom);
  endfunction

  // Every DC entry and every AC position once, in raster order.
  task automatic push_full_mb(input int density);
    for (int i = 0; i < 4; i++) push_coeff(1'b0, 2'($urandom), 4'(i), pick_level(density), 1'b0);
    for (int b = 0; b < 4; b++) begin
      for (int p = 0; p < 16; p++) begin
        push_coeff(1'b1, 2'(b), 4'(p), pick_level(density), 1'(b == 3 && p == 15));
      end
    end
  endtask

  // Random stimulus: mostly short updates that end in a scan, some noise with
  // the end marker anywhere, and now and then a complete macroblock.
  task automatic gen_random(input int target);
    int made;
    int roll;
    int n;
    logic kind;
    made = 0;
    while (made < target) begin
      roll = $urandom_range(99);
      if (roll < 70) begin
        n = $urandom_range(24, 4);
        for (int k = 0; k < n; k++) begin
          kind = 1'($urandom);
          push_coeff(kind, 2'($urandom),
                     (kind || $urandom_range(9) == 0) ? 4'($urandom) : 4'($urandom_range(3)),
                     pick_level(40), 1'(k == n - 1));
        end
        made += n;
      end else if (roll < 78) begin
        push_full_mb($urandom_range(30, 3));
        made += 68;
      end else begin
        n = $urandom_range(4, 1);
        for (int k = 0; k < n; k++) begin
          push_coeff(1'($urandom), 2'($urandom), 4'($urandom), 16'($urandom),
                     1'($urandom_range(3) == 0));
        end
        made += n;
      end
    end
  endtask

  // Wait until everything queued has been taken and every prediction has
  // been matched, then let the block settle before anything else changes.
  task automatic drain();
    while (coeff_q.size() != 0 || in_valid || pending_pairs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Phase 0: register defaults, sender idles lightly, receiver heavily.
    send_idle_pct = 35;
    recv_idle_pct = 81;
    // Zero-fill every entry first, so no scan ever reads an unwritten one.
    // This also gives the empty result, cleared although no AC was coded.
    push_full_mb(0);
    // Full-scale DC levels, one addressed through a position above three.
    // The lone unit AC levels cost less than the threshold, so AC is cleared.
    push_coeff(1'b0, 2'd0, 4'd0, 16'sh7FFF, 1'b0);
    push_coeff(1'b0, 2'd2, 4'd13, 16'sh8000, 1'b0);
    push_coeff(1'b1, 2'd0, 4'd1, 16'sd1, 1'b0);
    push_coeff(1'b1, 2'd3, 4'd15, -16'sd1, 1'b1);
    // A large AC level pushes the cost over the threshold.
    push_coeff(1'b1, 2'd1, 4'd4, 16'sh8000, 1'b1);
    // AC only; raster position 0 of an AC block is stored but never scanned.
    push_coeff(1'b1, 2'd2, 4'd0, 16'sh7FFF, 1'b0);
    push_coeff(1'b0, 2'd0, 4'd0, 16'sd0, 1'b0);
    push_coeff(1'b0, 2'd1, 4'd1, 16'sd0, 1'b1);
    // Back to an all-zero macroblock.
    push_coeff(1'b1, 2'd1, 4'd4, 16'sd0, 1'b0);
    push_coeff(1'b1, 2'd0, 4'd1, 16'sd0, 1'b0);
    push_coeff(1'b1, 2'd3, 4'd15, 16'sd0, 1'b1);
    // A single DC level with a nonzero, ignored block index.
    push_coeff(1'b0, 2'd3, 4'd3, -16'sd1, 1'b1);
    // Small AC levels at different runs inside one block.
    push_coeff(1'b1, 2'd2, 4'd10, 16'sd2, 1'b0);
    push_coeff(1'b1, 2'd2, 4'd5, 16'sd1, 1'b0);
    push_coeff(1'b1, 2'd2, 4'd15, -16'sd3, 1'b1);
    gen_random(50);
    drain();

    // Phase 1: never cleared, largest costs; idling the other way round.
    write_reg(CFG_COST_THRESHOLD, 64'd0);
    write_reg(CFG_LARGE_LEVEL_COST, 64'd1023);
    write_reg(CFG_RUN_COST_TABLE, {CFG_DATA_W{1'b1}});
    send_idle_pct = 81;
    recv_idle_pct = 35;
    push_full_mb(30);
    gen_random(50);
    drain();

    // Phase 2: zero costs against the largest threshold, so AC always drops.
    write_reg(CFG_COST_THRESHOLD, 64'd1023);
    write_reg(CFG_LARGE_LEVEL_COST, 64'd0);
    write_reg(CFG_RUN_COST_TABLE, 64'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    gen_random(50);
    drain();

    // Phase 3: random registers near the interesting range, no idling, and
    // one long receiver hold-off while the driver keeps offering items.
    write_reg(CFG_COST_THRESHOLD, CFG_DATA_W'($urandom_range(60)));
    write_reg(CFG_LARGE_LEVEL_COST, CFG_DATA_W'($urandom_range(1023)));
    write_reg(CFG_RUN_COST_TABLE, {$urandom, $urandom});
    hold_armed = 1'b1;
    push_full_mb(20);
    gen_random(50);
    drain();

    if (errors == 0 && pending_pairs.size() == 0) begin
      $display("tb_chroma_run_level_coeff_cost_top: done, clean");
    end else begin
      $display("tb_chroma_run_level_coeff_cost_top: done, errors");
    end
    $finish;
  end

endmodule
